// ===== hdl/lcg_pkg.sv =====
package lcg_pkg;

  localparam int STATE_BITS_DEF = 20;
  localparam int IRWIN_TERMS    = 12;

  localparam int CFG_W      = 20;
  localparam int MOD_W      = 21;
  localparam int RANGE_W    = 32;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_W-1:0]   SEED_RST       = CFG_W'(0);
  localparam logic [CFG_W-1:0]   MULT_RST       = CFG_W'(4096);
  localparam logic [CFG_W-1:0]   INC_RST        = CFG_W'(150889);
  localparam logic [MOD_W-1:0]   MOD_RST        = MOD_W'(714025);
  localparam logic [RANGE_W-1:0] RANGE_LOW_RST  = RANGE_W'(0);
  localparam logic [RANGE_W-1:0] RANGE_HIGH_RST = RANGE_W'(255);

  localparam logic [MOD_W-1:0]   MOD_MIN        = MOD_W'(2);

  localparam logic OP_UNIFORM = 1'b0;
  localparam logic OP_NORMAL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED,
    REG_MULT,
    REG_INC,
    REG_MOD,
    REG_RANGE_LOW,
    REG_RANGE_HIGH
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV_MUL,
    ST_ADV_DIV,
    ST_ADV_WAIT,
    ST_UNI_SPAN,
    ST_UNI_LOW,
    ST_NRM_BIAS,
    ST_FIN_DIV,
    ST_FIN_WAIT,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    MAC_ADV,
    MAC_SPAN,
    MAC_LOW,
    MAC_BIAS
  } mac_op_t;

  typedef struct packed {
    logic    en;
    mac_op_t op;
  } mac_ctrl_t;

endpackage

// ===== hdl/lcg_mac.sv =====
module lcg_mac #(
  parameter int STATE_BITS = lcg_pkg::STATE_BITS_DEF,
  parameter int ACC_W      = 56,
  parameter int SUM_W      = 25
) (
  input  logic                                clk,
  input  lcg_pkg::mac_ctrl_t                  ctrl,
  input  logic [lcg_pkg::CFG_W-1:0]           multiplier,
  input  logic [lcg_pkg::CFG_W-1:0]           increment,
  input  logic [STATE_BITS-1:0]               gen_state,
  input  logic [lcg_pkg::MOD_W-1:0]           modulus_eff,
  input  logic signed [lcg_pkg::RANGE_W-1:0]  range_low,
  input  logic signed [lcg_pkg::RANGE_W-1:0]  range_high,
  input  logic [SUM_W-1:0]                    sum,
  output logic signed [ACC_W-1:0]             acc
);

  localparam int MA_W = lcg_pkg::RANGE_W + 1;
  localparam int MB_W = ((STATE_BITS > lcg_pkg::MOD_W) ? STATE_BITS : lcg_pkg::MOD_W) + 1;
  localparam int PR_W = MA_W + MB_W;

  logic signed [MA_W-1:0]  op_a;
  logic signed [MB_W-1:0]  op_b;
  logic signed [ACC_W-1:0] addend;
  logic signed [PR_W-1:0]  prod;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    case (ctrl.op)
      lcg_pkg::MAC_ADV: begin
        op_a   = MA_W'(multiplier);
        op_b   = MB_W'(gen_state);
        addend = ACC_W'(increment);
      end
      lcg_pkg::MAC_SPAN: begin
        op_a   = MA_W'(range_high) - MA_W'(range_low);
        op_b   = MB_W'(gen_state);
        addend = '0;
      end
      lcg_pkg::MAC_LOW: begin
        op_a   = MA_W'(range_low);
        op_b   = MB_W'(modulus_eff);
        addend = acc_r;
      end
      lcg_pkg::MAC_BIAS: begin
        // 2*sum - terms*M
        op_a   = MA_W'(-lcg_pkg::IRWIN_TERMS);
        op_b   = MB_W'(modulus_eff);
        addend = ACC_W'({sum, 1'b0});
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        addend = '0;
      end
    endcase
  end

  assign prod    = op_a * op_b;
  assign acc_nxt = ACC_W'(prod) + addend;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== hdl/lcg_div.sv =====
module lcg_div #(
  parameter int DW  = 55,
  parameter int DVW = 22
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [$clog2(DW+1)-1:0]  count,
  input  logic [DW-1:0]            dividend,
  input  logic [DVW-1:0]           divisor,
  output logic                     busy,
  output logic [DW-1:0]            quotient,
  output logic [DVW-1:0]           remainder
);

  localparam int CNT_W = $clog2(DW+1);
  localparam int IX_W  = $clog2(DW);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    dvd_r;
  logic [DVW-1:0]   dsr_r;
  logic [DVW-1:0]   rem_r;
  logic [DW-1:0]    quo_r;

  logic             dvd_bit;
  logic [DVW:0]     cand;
  logic [DVW:0]     diff;
  logic             ge;
  logic [DVW-1:0]   rem_nxt;

  // restoring division, one quotient bit per cycle, MSB first
  assign dvd_bit = dvd_r[IX_W'(cnt_r - CNT_W'(1))];
  assign cand    = {rem_r, dvd_bit};
  assign diff    = cand - {1'b0, dsr_r};
  assign ge      = (cand >= {1'b0, dsr_r});
  assign rem_nxt = ge ? diff[DVW-1:0] : cand[DVW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= count;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  a_no_restart_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dsr_r))
    else $error("partial remainder not below divisor");

  a_ends_on_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == CNT_W'(1)) |=> !busy_r)
    else $error("divider did not finish after last bit");

endmodule

// ===== hdl/lcg_uniform_normal_generator.sv =====
// Linear congruential generator with uniform and Irwin-Hall normal draws.
// One transaction in gives one transaction out. The block handles one item
// at a time: in_stall stays high from acceptance until the result has been
// loaded into the output register. Every generator step and the final
// scaling run through one shared restoring divider that retires one bit per
// cycle, so the divider sets the latency: a uniform draw runs one generator
// step and one scale division, a normal draw twelve steps and one scale
// division. The next item can be accepted while the previous result is
// still waiting in the output register.
module lcg_uniform_normal_generator #(
  parameter int STATE_BITS = lcg_pkg::STATE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic                                 in_restart,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lcg_pkg::SAMPLE_W-1:0]  out_sample_value,
  output logic [STATE_BITS-1:0]                out_raw_state,

  input  logic                                 cfg_we,
  input  logic [lcg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lcg_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int ADV_W  = lcg_pkg::CFG_W + STATE_BITS + 1;
  localparam int UNI_W  = lcg_pkg::RANGE_W + lcg_pkg::MOD_W + 2;
  localparam int DW     = (ADV_W > UNI_W) ? ADV_W : UNI_W;
  localparam int ACC_W  = DW + 1;
  localparam int DVW    = lcg_pkg::MOD_W + 1;
  localparam int SUM_W  = lcg_pkg::MOD_W + $clog2(lcg_pkg::IRWIN_TERMS);
  localparam int CNT_W  = $clog2(DW + 1);
  localparam int TERM_W = $clog2(lcg_pkg::IRWIN_TERMS);
  localparam int CAP_W  = STATE_BITS + 1;
  localparam int CMP_W  = (CAP_W > lcg_pkg::MOD_W) ? CAP_W : lcg_pkg::MOD_W;
  localparam logic [CMP_W-1:0] MOD_CAP = CMP_W'(1) << STATE_BITS;

  // configuration registers
  logic [lcg_pkg::CFG_W-1:0]          seed_r;
  logic [lcg_pkg::CFG_W-1:0]          mult_r;
  logic [lcg_pkg::CFG_W-1:0]          inc_r;
  logic [lcg_pkg::MOD_W-1:0]          mod_r;
  logic signed [lcg_pkg::RANGE_W-1:0] range_low_r;
  logic signed [lcg_pkg::RANGE_W-1:0] range_high_r;

  lcg_pkg::seq_state_t state_r;
  lcg_pkg::seq_state_t state_nxt;

  logic                      op_r;
  logic [TERM_W-1:0]         term_r;
  logic [STATE_BITS-1:0]     gen_state_r;
  logic [SUM_W-1:0]          sum_r;

  logic                              out_valid_r;
  logic signed [lcg_pkg::SAMPLE_W-1:0] out_sample_r;
  logic [STATE_BITS-1:0]             out_raw_r;

  logic [lcg_pkg::MOD_W-1:0] eff_mod;
  logic                      in_acc;
  logic                      out_free;
  logic                      adv_done;
  logic                      out_load;

  lcg_pkg::mac_ctrl_t        mac_ctrl;
  logic signed [ACC_W-1:0]   acc;
  logic                      acc_neg;
  logic [DW-1:0]             acc_mag;

  logic                      div_start;
  logic [CNT_W-1:0]          div_count;
  logic [DVW-1:0]            div_divisor;
  logic                      div_busy;
  logic [DW-1:0]             div_quo;
  logic [DVW-1:0]            div_rem;
  logic [DW-1:0]             quo_signed;

  // modulus clamped to [2, 2^STATE_BITS]
  always_comb begin
    if (mod_r < lcg_pkg::MOD_MIN) begin
      eff_mod = lcg_pkg::MOD_MIN;
    end else if (CMP_W'(mod_r) > MOD_CAP) begin
      eff_mod = lcg_pkg::MOD_W'(MOD_CAP);
    end else begin
      eff_mod = mod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= lcg_pkg::SEED_RST;
      mult_r       <= lcg_pkg::MULT_RST;
      inc_r        <= lcg_pkg::INC_RST;
      mod_r        <= lcg_pkg::MOD_RST;
      range_low_r  <= lcg_pkg::RANGE_LOW_RST;
      range_high_r <= lcg_pkg::RANGE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcg_pkg::REG_SEED:       seed_r       <= cfg_wdata[lcg_pkg::CFG_W-1:0];
        lcg_pkg::REG_MULT:       mult_r       <= cfg_wdata[lcg_pkg::CFG_W-1:0];
        lcg_pkg::REG_INC:        inc_r        <= cfg_wdata[lcg_pkg::CFG_W-1:0];
        lcg_pkg::REG_MOD:        mod_r        <= cfg_wdata[lcg_pkg::MOD_W-1:0];
        lcg_pkg::REG_RANGE_LOW:  range_low_r  <= cfg_wdata[lcg_pkg::RANGE_W-1:0];
        lcg_pkg::REG_RANGE_HIGH: range_high_r <= cfg_wdata[lcg_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != lcg_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lcg_pkg::ST_ADV_MUL;
        end
      end
      lcg_pkg::ST_ADV_MUL:  state_nxt = lcg_pkg::ST_ADV_DIV;
      lcg_pkg::ST_ADV_DIV:  state_nxt = lcg_pkg::ST_ADV_WAIT;
      lcg_pkg::ST_ADV_WAIT: begin
        if (!div_busy) begin
          if (op_r == lcg_pkg::OP_UNIFORM) begin
            state_nxt = lcg_pkg::ST_UNI_SPAN;
          end else if (term_r == TERM_W'(lcg_pkg::IRWIN_TERMS - 1)) begin
            state_nxt = lcg_pkg::ST_NRM_BIAS;
          end else begin
            state_nxt = lcg_pkg::ST_ADV_MUL;
          end
        end
      end
      lcg_pkg::ST_UNI_SPAN: state_nxt = lcg_pkg::ST_UNI_LOW;
      lcg_pkg::ST_UNI_LOW:  state_nxt = lcg_pkg::ST_FIN_DIV;
      lcg_pkg::ST_NRM_BIAS: state_nxt = lcg_pkg::ST_FIN_DIV;
      lcg_pkg::ST_FIN_DIV:  state_nxt = lcg_pkg::ST_FIN_WAIT;
      lcg_pkg::ST_FIN_WAIT: begin
        if (!div_busy) begin
          state_nxt = lcg_pkg::ST_DONE;
        end
      end
      lcg_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = lcg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lcg_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    mac_ctrl.en = 1'b0;
    mac_ctrl.op = lcg_pkg::MAC_ADV;
    div_start   = 1'b0;
    div_count   = CNT_W'(DW);
    div_divisor = {1'b0, eff_mod};
    adv_done    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      lcg_pkg::ST_ADV_MUL: begin
        mac_ctrl.en = 1'b1;
        mac_ctrl.op = lcg_pkg::MAC_ADV;
      end
      lcg_pkg::ST_ADV_DIV: begin
        div_start = 1'b1;
        div_count = CNT_W'(ADV_W);
      end
      lcg_pkg::ST_ADV_WAIT: begin
        adv_done = !div_busy;
      end
      lcg_pkg::ST_UNI_SPAN: begin
        mac_ctrl.en = 1'b1;
        mac_ctrl.op = lcg_pkg::MAC_SPAN;
      end
      lcg_pkg::ST_UNI_LOW: begin
        mac_ctrl.en = 1'b1;
        mac_ctrl.op = lcg_pkg::MAC_LOW;
      end
      lcg_pkg::ST_NRM_BIAS: begin
        mac_ctrl.en = 1'b1;
        mac_ctrl.op = lcg_pkg::MAC_BIAS;
      end
      lcg_pkg::ST_FIN_DIV: begin
        div_start = 1'b1;
        // normal draw divides by 2*M
        if (op_r == lcg_pkg::OP_NORMAL) begin
          div_divisor = {eff_mod, 1'b0};
        end
      end
      lcg_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcg_pkg::ST_IDLE;
      term_r      <= '0;
      gen_state_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        term_r <= '0;
        if (in_restart) begin
          gen_state_r <= STATE_BITS'(seed_r);
        end
      end else if (adv_done) begin
        term_r      <= term_r + TERM_W'(1);
        gen_state_r <= STATE_BITS'(div_rem);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_operation;
      sum_r <= '0;
    end else if (adv_done) begin
      sum_r <= sum_r + SUM_W'(div_rem);
    end
    if (out_load) begin
      out_sample_r <= lcg_pkg::SAMPLE_W'(quo_signed);
      out_raw_r    <= gen_state_r;
    end
  end

  lcg_mac #(
    .STATE_BITS (STATE_BITS),
    .ACC_W      (ACC_W),
    .SUM_W      (SUM_W)
  ) u_mac (
    .clk         (clk),
    .ctrl        (mac_ctrl),
    .multiplier  (mult_r),
    .increment   (inc_r),
    .gen_state   (gen_state_r),
    .modulus_eff (eff_mod),
    .range_low   (range_low_r),
    .range_high  (range_high_r),
    .sum         (sum_r),
    .acc         (acc)
  );

  // sign-magnitude around the unsigned divider, truncation toward zero
  assign acc_neg    = acc[ACC_W-1];
  assign acc_mag    = DW'(acc_neg ? -acc : acc);
  assign quo_signed = acc_neg ? (~div_quo + DW'(1)) : div_quo;

  lcg_div #(
    .DW  (DW),
    .DVW (DVW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .count     (div_count),
    .dividend  (acc_mag),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_raw_state    = out_raw_r;

  // the counter sits at the term count after the last step of a normal draw
  a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    term_r <= TERM_W'(lcg_pkg::IRWIN_TERMS))
    else $error("step counter past last term");

  a_state_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcg_pkg::ST_DONE) |-> (CMP_W'(gen_state_r) < CMP_W'(eff_mod)))
    else $error("generator state not reduced below modulus");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcg_pkg::ST_NRM_BIAS) |->
      ((SUM_W + 1)'(sum_r) < (SUM_W + 1)'(lcg_pkg::IRWIN_TERMS) * (SUM_W + 1)'(eff_mod)))
    else $error("step sum exceeds terms times modulus");

  a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == lcg_pkg::ST_ADV_WAIT || state_r == lcg_pkg::ST_FIN_WAIT))
    else $error("divider running outside a wait state");

endmodule
